// ===== rtl/pca_pkg.sv =====
// Package for the phase current auto-ranging block: field widths, gain limits,
// configuration register indexes and the packed stream item layouts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

    // Converter reading and scale widths
    localparam int RAW_W   = 12;
    localparam int SCALE_W = 24;
    localparam int THR_W   = 12;
    localparam int OUT_W   = RAW_W + SCALE_W;  // 36-bit Q20.16 result
    localparam int CODE_W  = 3;

    // Gain code 0 is a gain of two, the top code a gain of 64
    localparam logic [CODE_W-1:0] TOP_GAIN_CODE = 3'd5;
    localparam logic [CODE_W-1:0] MIN_GAIN_CODE = 3'd0;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = SCALE_W;

    // Reset values of the thresholds
    localparam logic [THR_W-1:0] HALVE_THR_RST  = 12'd3584;
    localparam logic [THR_W-1:0] DOUBLE_THR_RST = 12'd512;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HALVE_THR  = 3'd0,
        CFG_DOUBLE_THR = 3'd1,
        CFG_SWAP_V_W   = 3'd2,
        CFG_SUPPLY_SCL = 3'd3,
        CFG_CURRENT_SCL = 3'd4
    } t_cfg_idx;

    // Input sample set, first field in the low bits (48 bits, whole bytes)
    typedef struct packed {
        logic [RAW_W-1:0] phase_w_raw;
        logic [RAW_W-1:0] phase_v_raw;
        logic [RAW_W-1:0] phase_u_raw;
        logic [RAW_W-1:0] supply_raw;
    } t_in_item;

    localparam int IN_DATA_W  = $bits(t_in_item);
    localparam int RES_BITS   = 4 * OUT_W + 3 * CODE_W;
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Result item, first field in the low bits, zero pad on top
    typedef struct packed {
        logic [OUT_DATA_W-RES_BITS-1:0] pad;
        logic [CODE_W-1:0]             gain_code_w;
        logic [CODE_W-1:0]             gain_code_v;
        logic [CODE_W-1:0]             gain_code_u;
        logic [OUT_W-1:0]              w_amps;
        logic [OUT_W-1:0]              v_amps;
        logic [OUT_W-1:0]              u_amps;
        logic [OUT_W-1:0]              supply_volts;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/phase_current_autorange.sv =====
// Top level of the phase current auto-ranging block: supply and phase current
// scaling with per-phase PGA gain tracking. Depends on pca_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+---------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready | supply, U, V, W raw readings
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready | volts, 3 currents, 3 gain codes
//  cfg       | in        | i_cfg_we (no wait)            | index i_cfg_addr, i_cfg_wdata
//
// One sample set per cycle sustained while the output is not stalled; the result
// passes through the input register, then the result register, before it is
// offered. The four multipliers and the gain update sit between those two
// registers.
// Synchronous active-low reset clears the valid flags and gain codes (gain of two)
// and loads the configuration reset values. A stalled output holds its result;
// the input register still drains into it as soon as the result is taken.

module phase_current_autorange (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // fields low to high: supply_raw, phase_u_raw, phase_v_raw, phase_w_raw
    input  wire  [pca_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // fields low to high: supply_volts, u_amps, v_amps, w_amps,
    // gain_code_u, gain_code_v, gain_code_w, zero pad
    output logic [pca_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    input  wire                              i_cfg_we,
    input  wire  [pca_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire  [pca_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    // Configuration registers
    logic [pca_pkg::THR_W-1:0]   r_halve_thr;
    logic [pca_pkg::THR_W-1:0]   r_double_thr;
    logic                        r_swap_v_w;
    logic [pca_pkg::SCALE_W-1:0] r_supply_scale;
    logic [pca_pkg::SCALE_W-1:0] r_current_scale;

    // Pipeline registers
    logic                        r_in_valid;
    pca_pkg::t_in_item           r_in_item;
    logic                        r_out_valid;
    pca_pkg::t_out_item          r_out_item;
    pca_pkg::t_out_item          n_out_item;

    // Gain state, one code per physical phase
    logic [pca_pkg::CODE_W-1:0]  r_gain_u;
    logic [pca_pkg::CODE_W-1:0]  r_gain_v;
    logic [pca_pkg::CODE_W-1:0]  r_gain_w;
    logic [pca_pkg::CODE_W-1:0]  n_gain_u;
    logic [pca_pkg::CODE_W-1:0]  n_gain_v;
    logic [pca_pkg::CODE_W-1:0]  n_gain_w;

    logic                        out_free;
    logic                        advance;
    logic                        in_xfer;

    logic [pca_pkg::OUT_W-1:0]   cur_u;
    logic [pca_pkg::OUT_W-1:0]   cur_v;
    logic [pca_pkg::OUT_W-1:0]   cur_w;

    // Divide the scaled reading by the PGA gain 2^(code+1)
    function automatic logic [pca_pkg::OUT_W-1:0] scale_phase(
        input logic [pca_pkg::RAW_W-1:0]   raw,
        input logic [pca_pkg::SCALE_W-1:0] scl,
        input logic [pca_pkg::CODE_W-1:0]  code
    );
        logic [pca_pkg::OUT_W-1:0]    prod;
        logic [pca_pkg::CODE_W:0]     sh;
        prod = pca_pkg::OUT_W'(raw) * pca_pkg::OUT_W'(scl);
        sh   = {1'b0, code} + (pca_pkg::CODE_W+1)'(1);
        return prod >> sh;
    endfunction

    // Halve has priority; a blocked halve falls through to the double test
    function automatic logic [pca_pkg::CODE_W-1:0] next_gain(
        input logic [pca_pkg::RAW_W-1:0]  raw,
        input logic [pca_pkg::CODE_W-1:0] code,
        input logic [pca_pkg::THR_W-1:0]  hi_thr,
        input logic [pca_pkg::THR_W-1:0]  lo_thr
    );
        logic [pca_pkg::CODE_W-1:0] res;
        res = code;
        if (raw > hi_thr && code != pca_pkg::MIN_GAIN_CODE) begin
            res = code - pca_pkg::CODE_W'(1);
        end else if (raw < lo_thr && code < pca_pkg::TOP_GAIN_CODE) begin
            res = code + pca_pkg::CODE_W'(1);
        end
        return res;
    endfunction

    // Handshake: result register frees when taken, input register drains into it
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Scaling and gain update for the sample in the input register
    always_comb begin
        cur_u = scale_phase(r_in_item.phase_u_raw, r_current_scale, r_gain_u);
        cur_v = scale_phase(r_in_item.phase_v_raw, r_current_scale, r_gain_v);
        cur_w = scale_phase(r_in_item.phase_w_raw, r_current_scale, r_gain_w);

        n_gain_u = next_gain(r_in_item.phase_u_raw, r_gain_u, r_halve_thr, r_double_thr);
        n_gain_v = next_gain(r_in_item.phase_v_raw, r_gain_v, r_halve_thr, r_double_thr);
        n_gain_w = next_gain(r_in_item.phase_w_raw, r_gain_w, r_halve_thr, r_double_thr);

        n_out_item              = '0;
        n_out_item.supply_volts = pca_pkg::OUT_W'(r_in_item.supply_raw)
                                  * pca_pkg::OUT_W'(r_supply_scale);
        n_out_item.u_amps       = cur_u;
        n_out_item.v_amps       = r_swap_v_w ? cur_w : cur_v;
        n_out_item.w_amps       = r_swap_v_w ? cur_v : cur_w;
        n_out_item.gain_code_u  = n_gain_u;
        n_out_item.gain_code_v  = n_gain_v;
        n_out_item.gain_code_w  = n_gain_w;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halve_thr     <= pca_pkg::HALVE_THR_RST;
            r_double_thr    <= pca_pkg::DOUBLE_THR_RST;
            r_swap_v_w      <= 1'b0;
            r_supply_scale  <= '0;
            r_current_scale <= '0;
        end else if (i_cfg_we) begin
            case (pca_pkg::t_cfg_idx'(i_cfg_addr))
                pca_pkg::CFG_HALVE_THR:   r_halve_thr     <= i_cfg_wdata[pca_pkg::THR_W-1:0];
                pca_pkg::CFG_DOUBLE_THR:  r_double_thr    <= i_cfg_wdata[pca_pkg::THR_W-1:0];
                pca_pkg::CFG_SWAP_V_W:    r_swap_v_w      <= i_cfg_wdata[0];
                pca_pkg::CFG_SUPPLY_SCL:  r_supply_scale  <= i_cfg_wdata;
                pca_pkg::CFG_CURRENT_SCL: r_current_scale <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= pca_pkg::t_in_item'(i_s_axis_tdata);
        end
    end

    // Result register and gain state move together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_gain_u    <= pca_pkg::MIN_GAIN_CODE;
            r_gain_v    <= pca_pkg::MIN_GAIN_CODE;
            r_gain_w    <= pca_pkg::MIN_GAIN_CODE;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_gain_u    <= n_gain_u;
                r_gain_v    <= n_gain_v;
                r_gain_w    <= n_gain_w;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_item;

    // Gain codes stay in range
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain_u <= pca_pkg::TOP_GAIN_CODE && r_gain_v <= pca_pkg::TOP_GAIN_CODE
        && r_gain_w <= pca_pkg::TOP_GAIN_CODE)
        else $error("gain code beyond top code");

    // Gain state only changes when a sample moves into the result register
    a_gain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_gain_u) && $stable(r_gain_v) && $stable(r_gain_w)))
        else $error("gain code changed without a sample");

    // A sample leaving the input register is offered on the output next cycle,
    // carrying the gain codes just stored
    a_result_offered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_m_axis_tvalid && r_out_item.gain_code_u == r_gain_u
        && r_out_item.gain_code_w == r_gain_w))
        else $error("result lost or gain codes mismatched");

endmodule

`default_nettype wire

// ===== verif/tb_phase_current_autorange.sv =====
// Self-checking testbench for phase_current_autorange: predicts every result item
// from the accepted sample sets and checks it field by field.
// Depends on pca_pkg and the phase_current_autorange RTL.
`timescale 1ns / 1ps

module tb_phase_current_autorange;

    localparam int QUIET_LIMIT = 2000;  // cycles without any transfer before giving up
    localparam int PRINT_LIMIT = 50;    // mismatch lines printed, the rest only counted
    localparam logic [pca_pkg::OUT_W-1:0] OUT_MAX = {pca_pkg::OUT_W{1'b1}};
    localparam logic [pca_pkg::RAW_W-1:0] RAW_MAX = {pca_pkg::RAW_W{1'b1}};
    localparam logic [pca_pkg::CFG_ADDR_W-1:0] FIRST_UNUSED_IDX = 3'd5;
    localparam logic [pca_pkg::CFG_ADDR_W-1:0] LAST_UNUSED_IDX  = 3'd7;

    // Per-phase reading trend for the random part
    typedef enum int {RAW_LOW, RAW_HIGH, RAW_EDGE, RAW_ANY} t_raw_trend;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic [pca_pkg::IN_DATA_W-1:0]     i_s_axis_tdata;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    logic [pca_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    logic                              i_cfg_we;
    logic [pca_pkg::CFG_ADDR_W-1:0]    i_cfg_addr;
    logic [pca_pkg::CFG_DATA_W-1:0]    i_cfg_wdata;

    // Local copy of the configuration and gain state
    logic [pca_pkg::THR_W-1:0]   halve_thr;
    logic [pca_pkg::THR_W-1:0]   double_thr;
    logic                        swap_vw;
    logic [pca_pkg::SCALE_W-1:0] supply_scale;
    logic [pca_pkg::SCALE_W-1:0] current_scale;
    logic [pca_pkg::CODE_W-1:0]  gain_u, gain_v, gain_w;

    pca_pkg::t_out_item pending_results[$];
    t_raw_trend         phase_trend[3];
    int                 error_count = 0;
    int                 quiet_cycles = 0;
    bit                 gaps_on = 1'b0;
    bit                 stalls_on = 1'b0;

    phase_current_autorange i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic logic [pca_pkg::OUT_W-1:0] clip_to_out(logic [63:0] value);
        return (value > 64'(OUT_MAX)) ? OUT_MAX : value[pca_pkg::OUT_W-1:0];
    endfunction

    // Raw reading times current scale, divided by the PGA gain 2^(code+1)
    function automatic logic [pca_pkg::OUT_W-1:0] phase_amps(
        logic [pca_pkg::RAW_W-1:0] raw, logic [pca_pkg::CODE_W-1:0] code);
        logic [63:0] prod;
        prod = 64'(raw) * 64'(current_scale);
        return clip_to_out(prod >> (int'(code) + 1));
    endfunction

    // Halving has priority; a blocked halve falls through to the double test
    function automatic logic [pca_pkg::CODE_W-1:0] ranged_gain(
        logic [pca_pkg::RAW_W-1:0] raw, logic [pca_pkg::CODE_W-1:0] code);
        if (raw > halve_thr && code != pca_pkg::MIN_GAIN_CODE)
            return code - pca_pkg::CODE_W'(1);
        if (raw < double_thr && code < pca_pkg::TOP_GAIN_CODE)
            return code + pca_pkg::CODE_W'(1);
        return code;
    endfunction

    task automatic predict_sample(pca_pkg::t_in_item s);
        pca_pkg::t_out_item r;
        logic [pca_pkg::OUT_W-1:0] amps_v, amps_w;
        r = '0;
        amps_v = phase_amps(s.phase_v_raw, gain_v);
        amps_w = phase_amps(s.phase_w_raw, gain_w);
        r.supply_volts = clip_to_out(64'(s.supply_raw) * 64'(supply_scale));
        r.u_amps       = phase_amps(s.phase_u_raw, gain_u);
        r.v_amps       = swap_vw ? amps_w : amps_v;
        r.w_amps       = swap_vw ? amps_v : amps_w;
        gain_u = ranged_gain(s.phase_u_raw, gain_u);
        gain_v = ranged_gain(s.phase_v_raw, gain_v);
        gain_w = ranged_gain(s.phase_w_raw, gain_w);
        r.gain_code_u = gain_u;
        r.gain_code_v = gain_v;
        r.gain_code_w = gain_w;
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------ checking

    task automatic report_failure(string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_failure($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic check_result(pca_pkg::t_out_item got);
        pca_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            report_failure("result transfer with no sample set pending");
            return;
        end
        want = pending_results.pop_front();
        check_field("supply_volts", 64'(got.supply_volts), 64'(want.supply_volts));
        check_field("u_amps", 64'(got.u_amps), 64'(want.u_amps));
        check_field("v_amps", 64'(got.v_amps), 64'(want.v_amps));
        check_field("w_amps", 64'(got.w_amps), 64'(want.w_amps));
        check_field("gain_code_u", 64'(got.gain_code_u), 64'(want.gain_code_u));
        check_field("gain_code_v", 64'(got.gain_code_v), 64'(want.gain_code_v));
        check_field("gain_code_w", 64'(got.gain_code_w), 64'(want.gain_code_w));
        check_field("pad", 64'(got.pad), 64'(want.pad));
    endtask

    // Both stream sides observed at the rising edge; results before new samples
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            check_result(pca_pkg::t_out_item'(o_m_axis_tdata));
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            predict_sample(pca_pkg::t_in_item'(i_s_axis_tdata));
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts
    initial begin
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------- drivers

    task automatic write_reg(logic [pca_pkg::CFG_ADDR_W-1:0] addr,
                             logic [pca_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        // block is idle, so the local copy can follow right away
        case (addr)
            pca_pkg::CFG_HALVE_THR:   halve_thr     = value[pca_pkg::THR_W-1:0];
            pca_pkg::CFG_DOUBLE_THR:  double_thr    = value[pca_pkg::THR_W-1:0];
            pca_pkg::CFG_SWAP_V_W:    swap_vw       = value[0];
            pca_pkg::CFG_SUPPLY_SCL:  supply_scale  = value[pca_pkg::SCALE_W-1:0];
            pca_pkg::CFG_CURRENT_SCL: current_scale = value[pca_pkg::SCALE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One sample set, with an optional gap ahead of it
    task automatic send_sample(pca_pkg::t_in_item s);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= pca_pkg::IN_DATA_W'({$urandom, $urandom});
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stop sending and let every pending result come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= pca_pkg::IN_DATA_W'({$urandom, $urandom});
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_all(logic [pca_pkg::THR_W-1:0] halve, logic [pca_pkg::THR_W-1:0] dbl,
                             logic swap, logic [pca_pkg::SCALE_W-1:0] sup_scl,
                             logic [pca_pkg::SCALE_W-1:0] cur_scl);
        wait_drained();
        write_reg(pca_pkg::CFG_HALVE_THR, pca_pkg::CFG_DATA_W'(halve));
        write_reg(pca_pkg::CFG_DOUBLE_THR, pca_pkg::CFG_DATA_W'(dbl));
        write_reg(pca_pkg::CFG_SWAP_V_W, pca_pkg::CFG_DATA_W'(swap));
        write_reg(pca_pkg::CFG_SUPPLY_SCL, sup_scl);
        write_reg(pca_pkg::CFG_CURRENT_SCL, cur_scl);
    endtask

    function automatic pca_pkg::t_in_item sample_set(
        logic [pca_pkg::RAW_W-1:0] sup, logic [pca_pkg::RAW_W-1:0] u,
        logic [pca_pkg::RAW_W-1:0] v, logic [pca_pkg::RAW_W-1:0] w);
        pca_pkg::t_in_item s;
        s.supply_raw  = sup;
        s.phase_u_raw = u;
        s.phase_v_raw = v;
        s.phase_w_raw = w;
        return s;
    endfunction

    // Reading that follows a trend, so gains get walked to both ends
    function automatic logic [pca_pkg::RAW_W-1:0] pick_raw(t_raw_trend trend);
        logic [pca_pkg::RAW_W-1:0] raw;
        case (trend)
            RAW_LOW:  raw = pca_pkg::RAW_W'($urandom_range(0, double_thr));
            RAW_HIGH: raw = pca_pkg::RAW_W'($urandom_range(halve_thr, RAW_MAX));
            RAW_EDGE: begin
                raw = $urandom_range(0, 1) ? halve_thr : double_thr;
                raw = pca_pkg::RAW_W'(32'(raw) + $urandom_range(0, 2) - 1);
            end
            default:  raw = pca_pkg::RAW_W'($urandom);
        endcase
        return raw;
    endfunction

    function automatic pca_pkg::t_in_item random_sample();
        logic [pca_pkg::RAW_W-1:0] sup;
        foreach (phase_trend[p])
            if ($urandom_range(0, 9) == 0)
                phase_trend[p] = t_raw_trend'($urandom_range(0, 3));
        sup = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? RAW_MAX : '0)
                                          : pca_pkg::RAW_W'($urandom);
        return sample_set(sup, pick_raw(phase_trend[0]), pick_raw(phase_trend[1]),
                          pick_raw(phase_trend[2]));
    endfunction

    task automatic random_config();
        logic [pca_pkg::THR_W-1:0] halve, dbl;
        halve = pca_pkg::THR_W'($urandom_range(2048, RAW_MAX));
        dbl   = pca_pkg::THR_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 4) == 0) begin
            // crossed thresholds now and then
            halve = pca_pkg::THR_W'($urandom_range(0, 2047));
            dbl   = pca_pkg::THR_W'($urandom_range(2048, RAW_MAX));
        end
        write_all(halve, dbl, 1'($urandom_range(0, 1)), pca_pkg::SCALE_W'($urandom),
                  pca_pkg::SCALE_W'($urandom));
    endtask

    // --------------------------------------------------------------------- tests

    // Reset thresholds and zero scales: outputs zero, gains still move
    task automatic test_reset_defaults();
        send_sample(sample_set(RAW_MAX, 12'd3585, 12'd3584, 12'd511));
        send_sample(sample_set('0, '0, 12'd512, RAW_MAX));
        send_sample(sample_set(RAW_MAX, 12'd511, '0, 12'd3585));
        send_sample(sample_set(12'd2048, 12'd3585, 12'd511, 12'd512));
    endtask

    // Walk gains into the top code and back down to the minimum
    task automatic test_gain_limits();
        write_all(pca_pkg::HALVE_THR_RST, pca_pkg::DOUBLE_THR_RST, 1'b0, '1, '1);
        repeat (6) send_sample(sample_set(RAW_MAX, '0, RAW_MAX, 12'd3000));
        repeat (6) send_sample(sample_set('0, RAW_MAX, '0, 12'd3584));
    endtask

    // Halve threshold below double threshold: halving wins unless at minimum
    task automatic test_crossed_thresholds();
        write_all(12'd100, 12'd200, 1'b0, 24'h010000, 24'h123456);
        repeat (2) send_sample(sample_set(12'd150, 12'd150, 12'd150, 12'd150));
        send_sample(sample_set(RAW_MAX, 12'd50, 12'd250, 12'd100));
    endtask

    // V/W swap, values wider than the register, writes to unused indexes
    task automatic test_register_writes();
        wait_drained();
        write_reg(pca_pkg::CFG_SWAP_V_W, 24'hFFFFFE);
        write_reg(pca_pkg::CFG_SWAP_V_W, 24'h5A5A5B);
        write_reg(pca_pkg::CFG_HALVE_THR, 24'hFFFFFF);
        write_reg(pca_pkg::CFG_DOUBLE_THR, 24'hABC123);
        write_reg(pca_pkg::CFG_SUPPLY_SCL, 24'h000001);
        write_reg(pca_pkg::CFG_CURRENT_SCL, 24'h800000);
        write_reg(FIRST_UNUSED_IDX, 24'hABCDEF);
        write_reg(LAST_UNUSED_IDX, 24'h000000);
        send_sample(sample_set(12'd1, 12'd1000, 12'd100, 12'd4000));
        send_sample(sample_set(12'd2, 12'd2000, 12'd4000, 12'd100));
        send_sample(sample_set(12'd3, 12'd3000, RAW_MAX, '0));
    endtask

    // Several settings, extremes first, with idling on both sides
    task automatic test_random_configs();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_all(RAW_MAX, '0, 1'b0, '1, '1);
                1: write_all('0, RAW_MAX, 1'b1, '0, '1);
                2: write_all('0, '0, 1'b1, '1, 24'h000001);
                default: random_config();
            endcase
            gaps_on   = (phase == 2) ? 1'b0 : 1'b1;
            stalls_on = (phase == 5) ? 1'b0 : 1'b1;
            for (int n = 0; n < 100; n++) begin
                // one pause mid-stream until everything has come back
                if (phase == 3 && n == 50)
                    wait_drained();
                send_sample(random_sample());
            end
        end
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        random_config();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (150) send_sample(random_sample());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = pca_pkg::CFG_HALVE_THR;
        i_cfg_wdata     = '0;
        halve_thr       = pca_pkg::HALVE_THR_RST;
        double_thr      = pca_pkg::DOUBLE_THR_RST;
        swap_vw         = 1'b0;
        supply_scale    = '0;
        current_scale   = '0;
        gain_u          = pca_pkg::MIN_GAIN_CODE;
        gain_v          = pca_pkg::MIN_GAIN_CODE;
        gain_w          = pca_pkg::MIN_GAIN_CODE;
        foreach (phase_trend[p])
            phase_trend[p] = RAW_ANY;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_gain_limits();
        test_crossed_thresholds();
        test_register_writes();
        test_random_configs();
        test_back_to_back();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
